// ===== design/obb_pkg.sv =====
// ----------------------------------------------------------------------------
// obb_pkg
// Shared types and constants of the orientation basis builder.
// ----------------------------------------------------------------------------
`default_nettype none

package obb_pkg;

  // item kinds
  localparam logic [2:0] KIND_TGT_UP  = 3'd0;
  localparam logic [2:0] KIND_TGT_DN  = 3'd1;
  localparam logic [2:0] KIND_DIR_UP  = 3'd2;
  localparam logic [2:0] KIND_DIR_DN  = 3'd3;
  localparam logic [2:0] KIND_RESCALE = 3'd4;

  localparam logic [5:0] SQRT_STEPS = 6'd32;
  localparam logic [5:0] DIV_STEPS  = 6'd34;
  localparam logic [3:0] PROD_LAST  = 4'd8;
  localparam logic [1:0] LAST_IDX   = 2'd2;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_CAPTURE,
    OP_MUL,
    OP_ACC_CLR,
    OP_ACC_ADD,
    OP_VM_PROD,
    OP_VM_ACC,
    OP_SQRT_START,
    OP_SQRT_STEP,
    OP_SC_STORE,
    OP_LOAD_VEC,
    OP_NORM_STEP,
    OP_DIV_START,
    OP_DIV_STEP,
    OP_WRITE,
    OP_ZERO_ROLE,
    OP_OUT
  } op_t;

  typedef enum logic [2:0] {
    SEL_BASIS_SQ,
    SEL_VM_SQ,
    SEL_LXLY,
    SEL_LXLX,
    SEL_LZLZ,
    SEL_LYLZ,
    SEL_VM_SM
  } mul_sel_t;

  typedef struct packed {
    op_t        op;
    mul_sel_t   sel;
    logic [1:0] role;
    logic [1:0] comp;
  } cmd_t;

  typedef struct packed {
    logic [2:0] kind;
    logic       sqrt_done;
    logic       div_done;
    logic       norm_ok;
    logic       zero;
    logic       out_free;
  } sts_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_DISPATCH,
    S_OLD_MUL,
    S_OLD_ACC,
    S_OLD_SQS,
    S_OLD_SQR,
    S_OLD_STORE,
    S_PROD,
    S_LOAD,
    S_NORM,
    S_SS_MUL,
    S_SS_ACC,
    S_LEN_SQS,
    S_LEN_SQR,
    S_Q_MUL,
    S_Q_DIVS,
    S_Q_DIV,
    S_Q_WRITE,
    S_ZERO,
    S_DONE
  } ctl_state_t;

endpackage

`default_nettype wire

// ===== design/obb_in_if.sv =====
// ----------------------------------------------------------------------------
// obb_in_if
// Input item channel: valid/ready with kind, vector and position.
// ----------------------------------------------------------------------------
`default_nettype none

interface obb_in_if import obb_pkg::*;;
  logic               valid;
  logic               ready;
  logic [2:0]         kind;
  logic signed [31:0] vec_x;
  logic signed [31:0] vec_y;
  logic signed [31:0] vec_z;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;

  modport source (output valid, kind, vec_x, vec_y, vec_z, pos_x, pos_y, pos_z,
                  input ready);
  modport sink (input valid, kind, vec_x, vec_y, vec_z, pos_x, pos_y, pos_z,
                output ready);
endinterface

`default_nettype wire

// ===== design/obb_out_if.sv =====
// ----------------------------------------------------------------------------
// obb_out_if
// Result item channel: valid/ready with the nine basis components.
// ----------------------------------------------------------------------------
`default_nettype none

interface obb_out_if import obb_pkg::*;;
  logic               valid;
  logic               ready;
  logic signed [31:0] right_x;
  logic signed [31:0] right_y;
  logic signed [31:0] right_z;
  logic signed [31:0] up_x;
  logic signed [31:0] up_y;
  logic signed [31:0] up_z;
  logic signed [31:0] look_x;
  logic signed [31:0] look_y;
  logic signed [31:0] look_z;

  modport source (output valid, right_x, right_y, right_z, up_x, up_y, up_z,
                  look_x, look_y, look_z, input ready);
  modport sink (input valid, right_x, right_y, right_z, up_x, up_y, up_z,
                look_x, look_y, look_z, output ready);
endinterface

`default_nettype wire

// ===== design/orientation_basis_builder.sv =====
// An aim item takes longer than a rescale item, as it first takes the roots of
//   the old basis lengths; kinds five to seven go straight to the result, and a
//   role that comes out zero skips its root and divides. The bit-serial root,
//   the bit-serial divider and the one shared 32x32 multiplier set the time;
//   normalising shifts one bit a cycle.
// Throughput: one item at a time; the next is taken once the result is in the
//   output register. Reset (rst_n low, synchronous) loads the identity basis.
// ----------------------------------------------------------------------------
// orientation_basis_builder
// Keeps a right/up/look basis and re-aims or rescales it per item.
// ----------------------------------------------------------------------------
`default_nettype none

module orientation_basis_builder import obb_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input wire logic clk,
  input wire logic rst_n,
  obb_in_if.sink   in_ch,
  obb_out_if.source out_ch
);

  cmd_t cmd;
  sts_t sts;

  logic signed [31:0] in_vec [3];
  logic signed [31:0] in_pos [3];
  logic signed [31:0] out_comp [9];

  // gather payload into arrays for the datapath
  assign in_vec[0] = in_ch.vec_x;
  assign in_vec[1] = in_ch.vec_y;
  assign in_vec[2] = in_ch.vec_z;
  assign in_pos[0] = in_ch.pos_x;
  assign in_pos[1] = in_ch.pos_y;
  assign in_pos[2] = in_ch.pos_z;

  // sequencer: in_ready is high only while waiting for an item
  obb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath: basis store, multiplier, root, divider, output register
  obb_dp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_kind   (in_ch.kind),
    .in_vec    (in_vec),
    .in_pos    (in_pos),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_comp  (out_comp)
  );

  assign out_ch.right_x = out_comp[0];
  assign out_ch.right_y = out_comp[1];
  assign out_ch.right_z = out_comp[2];
  assign out_ch.up_x    = out_comp[3];
  assign out_ch.up_y    = out_comp[4];
  assign out_ch.up_z    = out_comp[5];
  assign out_ch.look_x  = out_comp[6];
  assign out_ch.look_y  = out_comp[7];
  assign out_ch.look_z  = out_comp[8];

endmodule

`default_nettype wire

// ===== design/obb_dp.sv =====
// ----------------------------------------------------------------------------
// obb_dp
// Datapath: basis store, shared multiplier, bit-serial root and divider.
// ----------------------------------------------------------------------------
`default_nettype none

module obb_dp import obb_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire cmd_t               cmd,
  output      sts_t               sts,
  input  wire logic [2:0]         in_kind,
  input  wire logic signed [31:0] in_vec [3],
  input  wire logic signed [31:0] in_pos [3],
  output      logic               out_valid,
  input  wire logic               out_ready,
  output      logic signed [31:0] out_comp [9]
);

  localparam logic [31:0] UNIT = 32'(64'd1 << FRAC_BITS);

  logic signed [31:0] basis_r [9];
  logic [2:0]         kind_r;
  logic [31:0]        lm_r [3];
  logic               ln_r [3];
  logic [31:0]        sc_r [3];
  logic [63:0]        vm_r [3];
  logic               vn_r [3];
  logic [31:0]        sm_r;
  logic               sneg_r;
  logic [63:0]        prod_r;
  logic [63:0]        acc_r;
  logic [63:0]        sq_x_r;
  logic [34:0]        sq_rem_r;
  logic [31:0]        sq_root_r;
  logic [5:0]         sq_cnt_r;
  logic [32:0]        dv_rem_r;
  logic [33:0]        dv_n_r;
  logic [33:0]        dv_q_r;
  logic [5:0]         dv_cnt_r;
  logic               out_valid_r;
  logic signed [31:0] out_r [9];

  function automatic logic [3:0] bidx(input logic [1:0] r, input logic [1:0] c);
    return 4'({r, 1'b0}) + 4'(r) + 4'(c);
  endfunction

  function automatic logic [31:0] mag32(input logic signed [31:0] v);
    return v[31] ? 32'(-v) : 32'(v);
  endfunction

  // capture: target minus position, saturated; other kinds take the vector as is
  logic signed [31:0] dl [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      logic signed [32:0] df;
      df = 33'(in_vec[i]) - 33'(in_pos[i]);
      if (in_kind > KIND_TGT_DN) begin
        dl[i] = in_vec[i];
      end else if (df[32] != df[31]) begin
        dl[i] = df[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
      end else begin
        dl[i] = df[31:0];
      end
    end
  end

  // multiplier operands
  logic [31:0] opa, opb;
  logic [31:0] bmag;
  always_comb begin
    bmag = mag32(basis_r[bidx(cmd.role, cmd.comp)]);
    opa  = '0;
    opb  = '0;
    case (cmd.sel)
      SEL_BASIS_SQ: begin opa = bmag; opb = bmag; end
      SEL_VM_SQ:    begin opa = vm_r[cmd.comp][31:0]; opb = vm_r[cmd.comp][31:0]; end
      SEL_LXLY:     begin opa = lm_r[0]; opb = lm_r[1]; end
      SEL_LXLX:     begin opa = lm_r[0]; opb = lm_r[0]; end
      SEL_LZLZ:     begin opa = lm_r[2]; opb = lm_r[2]; end
      SEL_LYLZ:     begin opa = lm_r[1]; opb = lm_r[2]; end
      SEL_VM_SM:    begin opa = vm_r[cmd.comp][31:0]; opb = sm_r; end
      default:      begin opa = '0; opb = '0; end
    endcase
  end

  logic [63:0] mx;
  always_comb begin
    mx = vm_r[0];
    if (vm_r[1] > mx) mx = vm_r[1];
    if (vm_r[2] > mx) mx = vm_r[2];
  end

  // root step
  logic [34:0] sq_sh, sq_trial;
  assign sq_sh    = {sq_rem_r[32:0], sq_x_r[63:62]};
  assign sq_trial = {1'b0, sq_root_r, 2'b01};

  // divider
  logic [63:0] num_c;
  logic [32:0] dv_sh, dv_d;
  assign num_c = prod_r + {33'd0, sq_root_r[31:1]};
  assign dv_sh = {dv_rem_r[31:0], dv_n_r[33]};
  assign dv_d  = {1'b0, sq_root_r};

  // signed, saturated quotient
  logic signed [31:0] wr_val;
  always_comb begin
    if (vn_r[cmd.comp] != sneg_r) begin
      wr_val = (dv_q_r[33:31] != 3'd0) ? 32'sh8000_0000 : 32'(~dv_q_r[31:0] + 32'd1);
    end else begin
      wr_val = (dv_q_r[33:31] != 3'd0) ? 32'sh7fff_ffff : dv_q_r[31:0];
    end
  end

  // basis store and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 9; i++) begin
        basis_r[i] <= (i == 0 || i == 4 || i == 8) ? UNIT : 32'd0;
      end
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.op == OP_WRITE) begin
        basis_r[bidx(cmd.role, cmd.comp)] <= wr_val;
      end
      if (cmd.op == OP_ZERO_ROLE) begin
        for (int j = 0; j < 3; j++) begin
          basis_r[bidx(cmd.role, 2'(j))] <= '0;
        end
      end
      if (cmd.op == OP_OUT) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_OUT) begin
      for (int i = 0; i < 9; i++) out_r[i] <= basis_r[i];
    end
  end

  // unit counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_cnt_r <= '0;
      dv_cnt_r <= '0;
    end else begin
      if (cmd.op == OP_SQRT_START) sq_cnt_r <= SQRT_STEPS;
      else if (cmd.op == OP_SQRT_STEP) sq_cnt_r <= sq_cnt_r - 6'd1;
      if (cmd.op == OP_DIV_START) dv_cnt_r <= DIV_STEPS;
      else if (cmd.op == OP_DIV_STEP) dv_cnt_r <= dv_cnt_r - 6'd1;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_CAPTURE: begin
        kind_r <= in_kind;
        for (int i = 0; i < 3; i++) begin
          lm_r[i] <= mag32(dl[i]);
          ln_r[i] <= dl[i][31];
        end
      end
      OP_MUL:     prod_r <= opa * opb;
      OP_ACC_CLR: acc_r <= prod_r;
      OP_ACC_ADD: acc_r <= acc_r + prod_r;
      OP_VM_PROD: vm_r[cmd.comp] <= prod_r;
      OP_VM_ACC:  vm_r[cmd.comp] <= acc_r;
      OP_SQRT_START: begin
        sq_x_r    <= acc_r;
        sq_rem_r  <= '0;
        sq_root_r <= '0;
      end
      OP_SQRT_STEP: begin
        sq_x_r <= {sq_x_r[61:0], 2'b00};
        if (sq_sh >= sq_trial) begin
          sq_rem_r  <= sq_sh - sq_trial;
          sq_root_r <= {sq_root_r[30:0], 1'b1};
        end else begin
          sq_rem_r  <= sq_sh;
          sq_root_r <= {sq_root_r[30:0], 1'b0};
        end
      end
      OP_SC_STORE: sc_r[cmd.role] <= sq_root_r;
      OP_LOAD_VEC: begin
        if (kind_r == KIND_RESCALE) begin
          for (int j = 0; j < 3; j++) begin
            vm_r[j] <= {32'd0, mag32(basis_r[bidx(cmd.role, 2'(j))])};
            vn_r[j] <= basis_r[bidx(cmd.role, 2'(j))][31];
          end
          sm_r   <= lm_r[cmd.role];
          sneg_r <= ln_r[cmd.role];
        end else begin
          sm_r   <= sc_r[cmd.role];
          sneg_r <= 1'b0;
          case (cmd.role)
            2'd0: begin
              vm_r[0] <= {32'd0, lm_r[2]};
              vm_r[1] <= '0;
              vm_r[2] <= {32'd0, lm_r[0]};
              vn_r[0] <= ln_r[2] ^ kind_r[0];
              vn_r[1] <= 1'b0;
              vn_r[2] <= ~ln_r[0] ^ kind_r[0];
            end
            2'd1: begin
              vn_r[0] <= ~(ln_r[0] ^ ln_r[1]) ^ kind_r[0];
              vn_r[1] <= kind_r[0];
              vn_r[2] <= ~(ln_r[1] ^ ln_r[2]) ^ kind_r[0];
            end
            default: begin
              for (int j = 0; j < 3; j++) begin
                vm_r[j] <= {32'd0, lm_r[j]};
                vn_r[j] <= ln_r[j];
              end
            end
          endcase
        end
      end
      OP_NORM_STEP: begin
        for (int j = 0; j < 3; j++) begin
          vm_r[j] <= (mx[63:30] != '0) ? (vm_r[j] >> 1) : (vm_r[j] << 1);
        end
      end
      OP_DIV_START: begin
        dv_rem_r <= {3'd0, num_c[63:34]};
        dv_n_r   <= num_c[33:0];
      end
      OP_DIV_STEP: begin
        dv_n_r <= {dv_n_r[32:0], 1'b0};
        if (dv_sh >= dv_d) begin
          dv_rem_r <= dv_sh - dv_d;
          dv_q_r   <= {dv_q_r[32:0], 1'b1};
        end else begin
          dv_rem_r <= dv_sh;
          dv_q_r   <= {dv_q_r[32:0], 1'b0};
        end
      end
      default: ;
    endcase
  end

  assign sts.kind      = kind_r;
  assign sts.sqrt_done = (sq_cnt_r == '0);
  assign sts.div_done  = (dv_cnt_r == '0);
  assign sts.norm_ok   = (mx[63:30] == '0) && mx[29];
  assign sts.zero      = (mx == '0) || (sm_r == '0);
  assign sts.out_free  = !out_valid_r || out_ready;

  assign out_valid = out_valid_r;
  assign out_comp  = out_r;

endmodule

`default_nettype wire

// ===== design/obb_ctrl.sv =====
// ----------------------------------------------------------------------------
// obb_ctrl
// Sequencer: steps the datapath through lengths, products, roots, divides.
// ----------------------------------------------------------------------------
`default_nettype none

module obb_ctrl import obb_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output      logic in_ready,
  input  wire sts_t sts,
  output      cmd_t cmd
);

  ctl_state_t state_r, state_nxt;
  logic [1:0] role_r, role_nxt;
  logic [1:0] comp_r, comp_nxt;
  logic [3:0] pstep_r, pstep_nxt;

  logic aim;
  assign aim = (sts.kind <= KIND_DIR_DN);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      role_r  <= '0;
      comp_r  <= '0;
      pstep_r <= '0;
    end else begin
      state_r <= state_nxt;
      role_r  <= role_nxt;
      comp_r  <= comp_nxt;
      pstep_r <= pstep_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    role_nxt  = role_r;
    comp_nxt  = comp_r;
    pstep_nxt = pstep_r;
    unique case (state_r)
      S_IDLE:     if (in_valid) state_nxt = S_DISPATCH;
      S_DISPATCH: begin
        role_nxt = '0;
        comp_nxt = '0;
        if (aim) state_nxt = S_OLD_MUL;
        else if (sts.kind == KIND_RESCALE) state_nxt = S_LOAD;
        else state_nxt = S_DONE;
      end
      S_OLD_MUL:  state_nxt = S_OLD_ACC;
      S_OLD_ACC: begin
        if (comp_r == LAST_IDX) begin
          comp_nxt  = '0;
          state_nxt = S_OLD_SQS;
        end else begin
          comp_nxt  = comp_r + 2'd1;
          state_nxt = S_OLD_MUL;
        end
      end
      S_OLD_SQS:  state_nxt = S_OLD_SQR;
      S_OLD_SQR:  if (sts.sqrt_done) state_nxt = S_OLD_STORE;
      S_OLD_STORE: begin
        if (role_r == LAST_IDX) begin
          role_nxt  = '0;
          state_nxt = S_LOAD;
        end else begin
          role_nxt  = role_r + 2'd1;
          state_nxt = S_OLD_MUL;
        end
      end
      S_PROD: begin
        if (pstep_r == PROD_LAST) state_nxt = S_LOAD;
        else pstep_nxt = pstep_r + 4'd1;
      end
      S_LOAD:     state_nxt = S_NORM;
      S_NORM: begin
        comp_nxt = '0;
        if (sts.zero) state_nxt = S_ZERO;
        else if (sts.norm_ok) state_nxt = S_SS_MUL;
      end
      S_SS_MUL:   state_nxt = S_SS_ACC;
      S_SS_ACC: begin
        if (comp_r == LAST_IDX) begin
          comp_nxt  = '0;
          state_nxt = S_LEN_SQS;
        end else begin
          comp_nxt  = comp_r + 2'd1;
          state_nxt = S_SS_MUL;
        end
      end
      S_LEN_SQS:  state_nxt = S_LEN_SQR;
      S_LEN_SQR:  if (sts.sqrt_done) state_nxt = S_Q_MUL;
      S_Q_MUL:    state_nxt = S_Q_DIVS;
      S_Q_DIVS:   state_nxt = S_Q_DIV;
      S_Q_DIV:    if (sts.div_done) state_nxt = S_Q_WRITE;
      S_Q_WRITE, S_ZERO: begin
        if (state_r == S_Q_WRITE && comp_r != LAST_IDX) begin
          comp_nxt  = comp_r + 2'd1;
          state_nxt = S_Q_MUL;
        end else if (role_r == LAST_IDX) begin
          state_nxt = S_DONE;
        end else begin
          role_nxt  = role_r + 2'd1;
          comp_nxt  = '0;
          pstep_nxt = '0;
          // up vector needs its products built before loading
          state_nxt = (aim && role_r == 2'd0) ? S_PROD : S_LOAD;
        end
      end
      S_DONE:     if (sts.out_free) state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd.op   = OP_NONE;
    cmd.sel  = SEL_BASIS_SQ;
    cmd.role = role_r;
    cmd.comp = comp_r;
    in_ready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) cmd.op = OP_CAPTURE;
      end
      S_OLD_MUL:   begin cmd.op = OP_MUL; cmd.sel = SEL_BASIS_SQ; end
      S_OLD_ACC:   cmd.op = (comp_r == 2'd0) ? OP_ACC_CLR : OP_ACC_ADD;
      S_OLD_SQS,
      S_LEN_SQS:   cmd.op = OP_SQRT_START;
      S_OLD_SQR,
      S_LEN_SQR:   cmd.op = sts.sqrt_done ? OP_NONE : OP_SQRT_STEP;
      S_OLD_STORE: cmd.op = OP_SC_STORE;
      S_PROD: begin
        case (pstep_r)
          4'd0: begin cmd.op = OP_MUL; cmd.sel = SEL_LXLY; end
          4'd1: begin cmd.op = OP_VM_PROD; cmd.comp = 2'd0; end
          4'd2: begin cmd.op = OP_MUL; cmd.sel = SEL_LXLX; end
          4'd3: cmd.op = OP_ACC_CLR;
          4'd4: begin cmd.op = OP_MUL; cmd.sel = SEL_LZLZ; end
          4'd5: cmd.op = OP_ACC_ADD;
          4'd6: begin cmd.op = OP_VM_ACC; cmd.comp = 2'd1; end
          4'd7: begin cmd.op = OP_MUL; cmd.sel = SEL_LYLZ; end
          4'd8: begin cmd.op = OP_VM_PROD; cmd.comp = 2'd2; end
          default: cmd.op = OP_NONE;
        endcase
      end
      S_LOAD:      cmd.op = OP_LOAD_VEC;
      S_NORM:      cmd.op = (sts.zero || sts.norm_ok) ? OP_NONE : OP_NORM_STEP;
      S_SS_MUL:    begin cmd.op = OP_MUL; cmd.sel = SEL_VM_SQ; end
      S_SS_ACC:    cmd.op = (comp_r == 2'd0) ? OP_ACC_CLR : OP_ACC_ADD;
      S_Q_MUL:     begin cmd.op = OP_MUL; cmd.sel = SEL_VM_SM; end
      S_Q_DIVS:    cmd.op = OP_DIV_START;
      S_Q_DIV:     cmd.op = sts.div_done ? OP_NONE : OP_DIV_STEP;
      S_Q_WRITE:   cmd.op = OP_WRITE;
      S_ZERO:      cmd.op = OP_ZERO_ROLE;
      S_DONE:      if (sts.out_free) cmd.op = OP_OUT;
      default:     cmd.op = OP_NONE;
    endcase
  end

  a_sqrt_step: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_SQRT_STEP) |-> !sts.sqrt_done)
    else $error("root stepped past its last digit");

  a_div_step: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_DIV_STEP) |-> !sts.div_done)
    else $error("divider stepped past its last bit");

  a_out_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_OUT) |=> (state_r == S_IDLE))
    else $error("result issued without return to idle");

  a_role: assert property (@(posedge clk) disable iff (!rst_n)
    (role_r != 2'd3) && (comp_r != 2'd3))
    else $error("role or component index out of range");

endmodule

`default_nettype wire
